@@ hdl/tpf_pkg.sv @@
// shared types, constants and register codes of the tpm2 packet framer
`default_nettype none

package tpf_pkg;

    // packet framing bytes
    localparam logic [7:0] HDR_START = 8'h9C;
    localparam logic [7:0] HDR_TYPE  = 8'hDA;
    localparam logic [7:0] END_BYTE  = 8'h36;

    // register reset values
    localparam logic [15:0] MAX_PACKET_RST    = 16'd170;
    localparam logic [15:0] FRAME_BYTES_RST   = 16'd3;
    localparam logic [7:0]  TOTAL_PACKETS_RST = 8'd1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MAX_PACKET    = 2'd0;
    localparam logic [1:0] REG_FRAME_BYTES   = 2'd1;
    localparam logic [1:0] REG_TOTAL_PACKETS = 2'd2;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration seen by the front end
    typedef struct packed {
        logic [15:0] max_packet;
        logic [15:0] frame_bytes;
    } t_cfg;

    // one classified input beat, as queued for the back end
    typedef struct packed {
        logic [7:0]  data;
        logic        hdr_flag;
        logic        end_flag;
        logic [15:0] len;
        logic [7:0]  num;
    } t_cmd;

    // byte position within the results of one command
    typedef enum logic [2:0] {
        PH_START,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_NUM,
        PH_TOTAL,
        PH_DATA,
        PH_END
    } t_phase;

endpackage

`default_nettype wire

@@ hdl/tpf_front.sv @@
// front end: keeps frame and packet counters and classifies each input beat
`default_nettype none

module tpf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tpf_pkg::t_cfg i_cfg,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    output tpf_pkg::t_cmd      o_cmd
);
    import tpf_pkg::*;

    logic [15:0] r_frame_position, n_frame_position;
    logic [15:0] r_packet_offset,  n_packet_offset;
    logic [15:0] r_packet_length,  n_packet_length;
    logic [7:0]  r_packet_number,  n_packet_number;

    logic [15:0] mp, fb, pos0, off0, rem, len1, off1, pos1;
    logic [7:0]  num0, num1;
    logic        wrap, hdr, frame_end, end_flag;

    // classification of the beat on offer
    always_comb begin
        mp        = (i_cfg.max_packet == 16'd0) ? 16'd1 : i_cfg.max_packet;
        fb        = (i_cfg.frame_bytes == 16'd0) ? 16'd1 : i_cfg.frame_bytes;
        wrap      = (r_frame_position >= fb);
        pos0      = wrap ? 16'd0 : r_frame_position;
        off0      = wrap ? 16'd0 : r_packet_offset;
        num0      = wrap ? 8'd1 : r_packet_number;
        hdr       = (off0 == 16'd0) || (off0 >= r_packet_length);
        rem       = fb - pos0;
        len1      = hdr ? ((rem < mp) ? rem : mp) : r_packet_length;
        num1      = hdr ? num0 + 8'd1 : num0;
        off1      = (hdr ? 16'd0 : off0) + 16'd1;
        pos1      = pos0 + 16'd1;
        frame_end = (pos1 >= fb) || (pos1 == 16'd0);
        end_flag  = (off1 >= len1) || frame_end;

        n_packet_length  = len1;
        n_packet_offset  = end_flag ? 16'd0 : off1;
        n_frame_position = frame_end ? 16'd0 : pos1;
        n_packet_number  = frame_end ? 8'd1 : num1;

        o_cmd.data     = i_data_byte;
        o_cmd.hdr_flag = hdr;
        o_cmd.end_flag = end_flag;
        o_cmd.len      = len1;
        o_cmd.num      = num0;
    end

    // counters advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_position <= 16'd0;
            r_packet_offset  <= 16'd0;
            r_packet_length  <= 16'd0;
            r_packet_number  <= 8'd1;
        end else if (i_accept) begin
            r_frame_position <= n_frame_position;
            r_packet_offset  <= n_packet_offset;
            r_packet_length  <= n_packet_length;
            r_packet_number  <= n_packet_number;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tpf_queue.sv @@
// short register queue between front and back end
`default_nettype none

module tpf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_rdata
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/tpf_back.sv @@
// back end: expands each queued command into header, data and end bytes
`default_nettype none

module tpf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tpf_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    input  wire logic [7:0]    i_total_packets,
    output logic               o_pop,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_packet_end,
    output logic               o_last_of_run
);
    import tpf_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_mid, n_mid;
    t_phase     cur_phase;
    logic       load, emit;
    logic [7:0] byte_val;
    logic       end_val, last_val;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_packet_end, r_last_of_run;

    assign load      = !r_out_valid || !i_out_stall;
    assign emit      = load && !i_empty;
    assign cur_phase = r_mid ? r_phase : (i_cmd.hdr_flag ? PH_START : PH_DATA);

    // next state of the byte sequencer
    always_comb begin
        n_phase = r_phase;
        n_mid   = r_mid;
        if (emit) begin
            if (o_pop) begin
                n_mid   = 1'b0;
                n_phase = PH_START;
            end else begin
                n_mid = 1'b1;
                case (cur_phase)
                    PH_START:  n_phase = PH_TYPE;
                    PH_TYPE:   n_phase = PH_LEN_HI;
                    PH_LEN_HI: n_phase = PH_LEN_LO;
                    PH_LEN_LO: n_phase = PH_NUM;
                    PH_NUM:    n_phase = PH_TOTAL;
                    PH_TOTAL:  n_phase = PH_DATA;
                    PH_DATA:   n_phase = PH_END;
                    default:   n_phase = PH_START;
                endcase
            end
        end
    end

    // byte and flags for the current phase
    always_comb begin
        end_val  = 1'b0;
        last_val = 1'b0;
        case (cur_phase)
            PH_START:  byte_val = HDR_START;
            PH_TYPE:   byte_val = HDR_TYPE;
            PH_LEN_HI: byte_val = i_cmd.len[15:8];
            PH_LEN_LO: byte_val = i_cmd.len[7:0];
            PH_NUM:    byte_val = i_cmd.num;
            PH_TOTAL:  byte_val = i_total_packets;
            PH_DATA: begin
                byte_val = i_cmd.data;
                last_val = !i_cmd.end_flag;
            end
            PH_END: begin
                byte_val = END_BYTE;
                end_val  = 1'b1;
                last_val = 1'b1;
            end
            default:   byte_val = 8'd0;
        endcase
        o_pop = emit && last_val;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_mid   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_mid   <= n_mid;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte    <= byte_val;
            r_packet_end  <= end_val;
            r_last_of_run <= last_val;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_packet_end  = r_packet_end;
    assign o_last_of_run = r_last_of_run;

endmodule

`default_nettype wire

@@ hdl/tpm2_packet_framer.sv @@
// top level of the tpm2 packet framer: register port, front, queue and back
//
// channel   direction  handshake                     payload
// input     in         i_in_valid / o_in_stall       i_data_byte
// output    out        o_out_valid / i_out_stall     o_out_byte, o_packet_end, o_last_of_run
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// an input beat yields one to eight output beats, sent one at a time by the back end sequencer
// a beat inside a packet yields one output beat, a packet's first beat seven and its last one more
// the front end accepts a beat whenever the command queue has room, one per cycle
// synchronous reset clears counters, queue, sequencer and output valid; registers to defaults
// a stalled output holds its beat; the queue fills and then stalls the input side
`default_nettype none

module tpm2_packet_framer #(
    parameter int QUEUE_DEPTH = tpf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_packet_end,
    output logic             o_last_of_run
);
    import tpf_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    logic [15:0] r_max_packet;
    logic [15:0] r_frame_bytes;
    logic [7:0]  r_total_packets;
    logic [1:0]  reg_idx;
    logic        wr_en;

    t_cfg       cfg;
    t_cmd       cmd_in, cmd_out;
    logic       accept, q_full, q_empty, q_pop;
    logic [CMD_W-1:0] q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet    <= MAX_PACKET_RST;
            r_frame_bytes   <= FRAME_BYTES_RST;
            r_total_packets <= TOTAL_PACKETS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_PACKET:    r_max_packet    <= pwdata[15:0];
                REG_FRAME_BYTES:   r_frame_bytes   <= pwdata[15:0];
                REG_TOTAL_PACKETS: r_total_packets <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            REG_MAX_PACKET:    prdata = {16'd0, r_max_packet};
            REG_FRAME_BYTES:   prdata = {16'd0, r_frame_bytes};
            REG_TOTAL_PACKETS: prdata = {24'd0, r_total_packets};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.max_packet  = r_max_packet;
    assign cfg.frame_bytes = r_frame_bytes;

    // input handshake
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    tpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_cmd       (cmd_in)
    );

    tpf_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_wdata (cmd_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    assign cmd_out = t_cmd'(q_rdata);

    tpf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_out),
        .i_empty         (q_empty),
        .i_total_packets (r_total_packets),
        .o_pop           (q_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_packet_end    (o_packet_end),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire

@@ hdl/tpf_checker.sv @@
// port-level checks of the tpm2 packet framer and their binding
`default_nettype none

module tpf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       pready,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_packet_end,
    input wire logic       o_last_of_run
);
    import tpf_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_packet_end) && $stable(o_last_of_run))
        else $error("output beat changed while stalled");

    // end flag only on the end byte
    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |-> o_out_byte == END_BYTE)
        else $error("packet end flag on a byte other than the end byte");

    // end byte always closes the run of its input beat
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |-> o_last_of_run)
        else $error("end byte not marked as last of run");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind tpm2_packet_framer tpf_checker u_tpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_packet_end  (o_packet_end),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire

@@ tb/tpm2_packet_framer_tb.sv @@
// self-checking testbench of the tpm2 packet framer, with its own framing predictor
`timescale 1ns / 1ps
`default_nettype none

module tpm2_packet_framer_tb;
    import tpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // one beat on the output channel
    typedef struct {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       last_of_run;
    } t_framed_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_packet_end;
    logic        o_last_of_run;

    tpm2_packet_framer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_packet_end  (o_packet_end),
        .o_last_of_run (o_last_of_run)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // colour bytes waiting to be sent and packet beats still owed by the block
    logic [7:0]   colour_bytes_q[$];
    t_framed_beat packet_beats_q[$];

    // predictor copy of the registers and framing counters
    logic [15:0] cfg_max_packet    = MAX_PACKET_RST;
    logic [15:0] cfg_frame_bytes   = FRAME_BYTES_RST;
    logic [7:0]  cfg_total_packets = TOTAL_PACKETS_RST;
    logic [15:0] frame_pos  = '0;
    logic [15:0] pkt_offset = '0;
    logic [15:0] pkt_length = '0;
    logic [7:0]  pkt_number = 8'd1;

    int   fail_count = 0;
    int   idle_cycles = 0;
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic in_burst = 1'b0;
    logic out_burst = 1'b0;
    int   in_gap = 0;
    int   out_hold = 0;

    function automatic void add_beat(input logic [7:0] value, input logic is_end);
        t_framed_beat b;
        b.out_byte    = value;
        b.packet_end  = is_end;
        b.last_of_run = 1'b0;
        packet_beats_q.push_back(b);
    endfunction

    // works out the beats one colour byte causes and advances the framing state
    function automatic void frame_colour_byte(input logic [7:0] data);
        int unsigned  mp;
        int unsigned  fb;
        int unsigned  rem;
        t_framed_beat tail;
        mp = (cfg_max_packet == 0) ? 1 : cfg_max_packet;
        fb = (cfg_frame_bytes == 0) ? 1 : cfg_frame_bytes;

        // registers shrunk below the current position: restart the frame
        if (frame_pos >= fb) begin
            frame_pos  = '0;
            pkt_offset = '0;
            pkt_number = 8'd1;
        end

        // open a packet with its header
        if (pkt_offset == 0 || pkt_offset >= pkt_length) begin
            rem        = fb - frame_pos;
            pkt_length = (rem < mp) ? rem[15:0] : mp[15:0];
            pkt_offset = '0;
            add_beat(HDR_START, 1'b0);
            add_beat(HDR_TYPE, 1'b0);
            add_beat(pkt_length[15:8], 1'b0);
            add_beat(pkt_length[7:0], 1'b0);
            add_beat(pkt_number, 1'b0);
            add_beat(cfg_total_packets, 1'b0);
            pkt_number = pkt_number + 8'd1;
        end

        add_beat(data, 1'b0);
        pkt_offset = pkt_offset + 16'd1;
        frame_pos  = frame_pos + 16'd1;

        // close the packet on its length or at the end of the frame
        if (pkt_offset >= pkt_length || frame_pos >= fb || frame_pos == 0) begin
            add_beat(END_BYTE, 1'b1);
            pkt_offset = '0;
            if (frame_pos >= fb || frame_pos == 0) begin
                frame_pos  = '0;
                pkt_number = 8'd1;
            end
        end

        tail = packet_beats_q.pop_back();
        tail.last_of_run = 1'b1;
        packet_beats_q.push_back(tail);
    endfunction

    // input driver: one colour byte per beat, random gap before the next
    always @(negedge i_clk) begin
        if (!(i_in_valid && !in_taken)) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (colour_bytes_q.size() != 0) begin
                i_data_byte <= colour_bytes_q.pop_front();
                i_in_valid  <= 1'b1;
                in_gap = in_burst ? 0 : $urandom_range(0, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall driver: random hold-off after each accepted beat
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_hold = out_burst ? 0 : $urandom_range(0, 10);
        end
        if (out_hold > 0) begin
            out_hold = out_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: check output beats, predict on accepted input beats, watchdog
    always @(posedge i_clk) begin
        t_framed_beat exp_beat;
        logic         in_acc;
        logic         out_acc;
        in_acc  = i_rst_n && i_in_valid && !o_in_stall;
        out_acc = i_rst_n && o_out_valid && !i_out_stall;

        if (out_acc) begin
            if (packet_beats_q.size() == 0) begin
                $error("output beat with nothing expected: out_byte %0h", o_out_byte);
                fail_count++;
            end else begin
                exp_beat = packet_beats_q.pop_front();
                if (o_out_byte !== exp_beat.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", exp_beat.out_byte, o_out_byte);
                    fail_count++;
                end
                if (o_packet_end !== exp_beat.packet_end) begin
                    $error("packet_end: expected %0b, got %0b",
                           exp_beat.packet_end, o_packet_end);
                    fail_count++;
                end
                if (o_last_of_run !== exp_beat.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           exp_beat.last_of_run, o_last_of_run);
                    fail_count++;
                end
            end
        end

        if (in_acc) begin
            frame_colour_byte(i_data_byte);
        end

        in_taken  <= in_acc;
        out_taken <= out_acc;

        if (in_acc || out_acc) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** tpm2_packet_framer: FAILED **");
                $finish;
            end
        end
    end

    // register write over the configuration port, upper bits filled at random
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        logic [31:0] word;
        word = $urandom;
        if (idx == REG_TOTAL_PACKETS) begin
            word[7:0] = value[7:0];
        end else begin
            word[15:0] = value;
        end
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_MAX_PACKET:    cfg_max_packet    = word[15:0];
            REG_FRAME_BYTES:   cfg_frame_bytes   = word[15:0];
            REG_TOTAL_PACKETS: cfg_total_packets = word[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] mp, input logic [15:0] fb,
                             input logic [7:0] tp);
        write_reg(REG_MAX_PACKET, mp);
        write_reg(REG_FRAME_BYTES, fb);
        write_reg(REG_TOTAL_PACKETS, {8'd0, tp});
    endtask

    // wait until every queued byte is taken and every beat has come out
    task automatic wait_idle();
        while (colour_bytes_q.size() != 0 || i_in_valid || packet_beats_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    logic [15:0] mp_r;
    logic [15:0] fb_r;
    logic [7:0]  tp_r;
    int          sent;
    int          n_items;

    // stimulus sequence
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // default registers: a three byte frame, field extremes
        colour_bytes_q = '{8'h00, 8'hFF, 8'h5A};
        wait_idle();

        // several packets per frame with a short last one
        write_all(16'd2, 16'd5, 8'd3);
        colour_bytes_q = '{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h11};
        wait_idle();

        // zero registers: size one frames, zero total in header
        write_all(16'd0, 16'd0, 8'd0);
        colour_bytes_q = '{8'hAA, 8'h55};
        wait_idle();

        // frame size cut below the open packet's length, then below the position
        write_all(16'd8, 16'd10, 8'd2);
        colour_bytes_q = '{8'h10, 8'h20};
        wait_idle();
        write_reg(REG_FRAME_BYTES, 16'd3);
        colour_bytes_q = '{8'h30, 8'h40, 8'h50};
        wait_idle();
        write_reg(REG_FRAME_BYTES, 16'd1);
        colour_bytes_q = '{8'h60};
        wait_idle();

        // largest registers
        write_all(16'hFFFF, 16'hFFFF, 8'hFF);
        colour_bytes_q = '{8'hC3, 8'h3C, 8'hE7};
        wait_idle();

        // random phases: mostly small frames, some odd register values
        sent = 0;
        while (sent < 140) begin
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                fb_r = 16'($urandom_range(1, 30));
                mp_r = 16'($urandom_range(1, fb_r + 3));
                if ($urandom_range(0, 7) == 0) mp_r = 16'd0;
                if ($urandom_range(0, 9) == 0) fb_r = 16'($urandom_range(31, 65535));
                if (mp_r == 0)
                    tp_r = fb_r[7:0];
                else
                    tp_r = 8'((fb_r + mp_r - 1) / mp_r);
                if ($urandom_range(0, 5) == 0) tp_r = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0: write_reg(REG_FRAME_BYTES, fb_r);
                    1: write_reg(REG_MAX_PACKET, mp_r);
                    default: write_all(mp_r, fb_r, tp_r);
                endcase
            end
            n_items = $urandom_range(12, 30);
            repeat (n_items) colour_bytes_q.push_back(8'($urandom_range(0, 255)));
            sent = sent + n_items;
            wait_idle();
        end

        // let any stray beat show itself
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** tpm2_packet_framer: PASSED **");
        end else begin
            $display("** tpm2_packet_framer: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
